[hdl/idsd_pkg.sv]
// shared constants, types and sine rom builder for the interpolated sine dds
`timescale 1ns / 1ps

package idsd_pkg;

    localparam int TABLE_DEPTH   = 2048;
    localparam int FRACTION_BITS = 5;

    localparam int PHASE_W  = 16;
    localparam int SAMPLE_W = 8;
    localparam int IDX_W    = $clog2(TABLE_DEPTH);
    localparam int SCALED_W = PHASE_W - FRACTION_BITS;
    localparam int DIFF_W   = SAMPLE_W + 1;
    localparam int PROD_W   = DIFF_W + FRACTION_BITS + 1;
    localparam int VAL_W    = PROD_W + 1;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_ENABLE = 1'd1;

    localparam logic REQ_TICK       = 1'b0;
    localparam logic REQ_LOAD_PHASE = 1'b1;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 8'd255;

    localparam logic [63:0] Q_ONE     = 64'h4000_0000_0000_0000;
    localparam logic [63:0] Q_HALF_PI = 64'h6487_ED51_10B4_611A;
    localparam logic [63:0] DEPTH64   = 64'(TABLE_DEPTH);
    localparam int          SER_TERMS = 60;

    // divisor pairs (k+1)*(k+2) of the taylor series
    localparam logic [63:0] SER_DIV [SER_TERMS] = '{
        64'd2,    64'd6,    64'd12,   64'd20,   64'd30,   64'd42,   64'd56,   64'd72,
        64'd90,   64'd110,  64'd132,  64'd156,  64'd182,  64'd210,  64'd240,  64'd272,
        64'd306,  64'd342,  64'd380,  64'd420,  64'd462,  64'd506,  64'd552,  64'd600,
        64'd650,  64'd702,  64'd756,  64'd812,  64'd870,  64'd930,  64'd992,  64'd1056,
        64'd1122, 64'd1190, 64'd1260, 64'd1332, 64'd1406, 64'd1482, 64'd1560, 64'd1640,
        64'd1722, 64'd1806, 64'd1892, 64'd1980, 64'd2070, 64'd2162, 64'd2256, 64'd2352,
        64'd2450, 64'd2550, 64'd2652, 64'd2756, 64'd2862, 64'd2970, 64'd3080, 64'd3192,
        64'd3306, 64'd3422, 64'd3540, 64'd3660
    };

    typedef logic [SAMPLE_W-1:0] sine_rom_t [TABLE_DEPTH];

    // truncated q2.62 product
    function automatic logic [63:0] q_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    function automatic logic [63:0] series(input logic [63:0] start, input logic [63:0] x2,
                                           input int k_start);
        logic [63:0] sum;
        logic [63:0] term;
        logic        sub;
        int          k;
        sum  = start;
        term = start;
        sub  = 1'b1;
        k    = k_start;
        while ((term != 64'd0) && (k < SER_TERMS)) begin
            term = q_mul(term, x2) / SER_DIV[k];
            sum  = sub ? (sum - term) : (sum + term);
            sub  = !sub;
            k    = k + 2;
        end
        return sum;
    endfunction

    function automatic logic [SAMPLE_W-1:0] table_entry(input int i);
        logic [63:0]  four_i;
        logic [63:0]  quad;
        logic [63:0]  rem;
        logic         swap;
        logic [63:0]  x;
        logic [63:0]  x2;
        logic [63:0]  s;
        logic [63:0]  c;
        logic [63:0]  mag;
        logic [63:0]  u;
        logic [127:0] p;
        logic [63:0]  hi;
        logic         use_cos;
        logic         neg;
        four_i = 64'd4 * 64'(i);
        quad   = four_i / DEPTH64;
        rem    = four_i - quad * DEPTH64;
        swap   = 1'b0;
        if ((64'd2 * rem) > DEPTH64) begin
            rem  = DEPTH64 - rem;
            swap = 1'b1;
        end
        x  = (Q_HALF_PI / DEPTH64) * rem + ((Q_HALF_PI % DEPTH64) * rem) / DEPTH64;
        x2 = q_mul(x, x);
        s  = series(x, x2, 1);
        c  = series(Q_ONE, x2, 0);
        use_cos = (quad[0] != 1'b0) != swap;
        mag = use_cos ? c : s;
        neg = quad[1];
        u   = neg ? (Q_ONE - mag) : (Q_ONE + mag);
        p   = {64'd0, u} * 128'd255;
        hi  = p[126:63];
        return (hi > 64'd255) ? SAMPLE_MAX : hi[SAMPLE_W-1:0];
    endfunction

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t rom;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            rom[i] = table_entry(i);
        end
        return rom;
    endfunction

endpackage

[hdl/idsd_if.sv]
// request and sample channel interfaces of the interpolated sine dds
`timescale 1ns / 1ps

interface idsd_req_if;
    logic                            valid;
    logic                            ready;
    logic                            req_type;
    logic [idsd_pkg::PHASE_W-1:0]    phase_value;

    modport source (output valid, output req_type, output phase_value, input ready);
    modport sink   (input valid, input req_type, input phase_value, output ready);
endinterface

interface idsd_smp_if;
    logic                            valid;
    logic                            ready;
    logic [idsd_pkg::SAMPLE_W-1:0]   dac_sample;

    modport source (output valid, output dac_sample, input ready);
    modport sink   (input valid, input dac_sample, output ready);
endinterface

[hdl/interpolated_sine_dds_core.sv]
// top level of the interpolated sine dds: phase accumulator, sine rom and interpolator
`timescale 1ns / 1ps

// Usage:
// req carries one request a cycle while req.ready is high: req_type 0 is a
// sample tick; req_type 1 loads phase_value into the phase accumulator, no sample.
// A tick gives one sample on the smp channel only while output_enable is set; it
// then advances the phase by phase_step. A disabled tick is taken and dropped.
// Configuration: cfg_we with cfg_index 0 writes phase_step, index 1 writes
// output_enable (bit 0 of cfg_data); write only while the block is idle.
// Throughput: one request every cycle while req.ready is high. Pipeline: the rom
// read stage registers both sine rom reads (current and next entry) of an accepted
// tick; the output stage then registers the clamped, interpolated sample and smp.valid.
// Stall: when smp.ready is low with a sample waiting, the pipeline holds and
// req.ready drops only once the rom read stage is also full.
// Reset: phase accumulator, phase_step and output_enable clear to zero and both
// stages empty; the sine rom is constant and needs no fill.
module interpolated_sine_dds_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [idsd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [idsd_pkg::CFG_DATA_W-1:0]      cfg_data,
    idsd_req_if.sink                             req,
    idsd_smp_if.source                           smp
);

    localparam idsd_pkg::sine_rom_t SINE_ROM = idsd_pkg::build_sine_rom();

    logic [idsd_pkg::PHASE_W-1:0]        phase_accum_reg;
    logic [idsd_pkg::PHASE_W-1:0]        phase_step_reg;
    logic                                output_enable_reg;

    logic                                rd_valid_reg;
    logic [idsd_pkg::SAMPLE_W-1:0]       cur_reg;
    logic [idsd_pkg::SAMPLE_W-1:0]       nxt_reg;
    logic [idsd_pkg::FRACTION_BITS-1:0]  frac_reg;

    logic                                out_valid_reg;
    logic [idsd_pkg::SAMPLE_W-1:0]       sample_reg;
    logic [idsd_pkg::SAMPLE_W-1:0]       sample_next;

    logic                                out_adv;
    logic                                rd_free;
    logic                                req_acc;
    logic                                tick_go;

    logic [idsd_pkg::SCALED_W-1:0]       scaled;
    logic [idsd_pkg::IDX_W-1:0]          idx;
    logic [idsd_pkg::IDX_W-1:0]          nxt_idx;
    logic [idsd_pkg::FRACTION_BITS-1:0]  frac;

    logic signed [idsd_pkg::DIFF_W-1:0]  diff;
    logic signed [idsd_pkg::PROD_W-1:0]  prod;
    logic signed [idsd_pkg::PROD_W-1:0]  delta;
    logic signed [idsd_pkg::VAL_W-1:0]   val;

    assign out_adv   = !out_valid_reg || smp.ready;
    assign rd_free   = !rd_valid_reg || out_adv;
    assign req.ready = rd_free;
    assign req_acc   = req.valid && rd_free;
    assign tick_go   = req_acc && (req.req_type == idsd_pkg::REQ_TICK) && output_enable_reg;

    assign smp.valid      = out_valid_reg;
    assign smp.dac_sample = sample_reg;

    // rom addressing
    always_comb
    begin
        scaled  = phase_accum_reg[idsd_pkg::PHASE_W-1:idsd_pkg::FRACTION_BITS];
        idx     = idsd_pkg::IDX_W'(scaled % idsd_pkg::TABLE_DEPTH);
        nxt_idx = (32'(idx) + 32'd1 == idsd_pkg::TABLE_DEPTH) ? '0 : idx + 1'b1;
        frac    = phase_accum_reg[idsd_pkg::FRACTION_BITS-1:0];
    end

    // linear interpolation with floor shift and clamp
    always_comb
    begin
        diff  = $signed({1'b0, nxt_reg}) - $signed({1'b0, cur_reg});
        prod  = idsd_pkg::PROD_W'(diff) * $signed({1'b0, frac_reg});
        delta = prod >>> idsd_pkg::FRACTION_BITS;
        val   = $signed({{(idsd_pkg::VAL_W - idsd_pkg::SAMPLE_W){1'b0}}, cur_reg})
                + idsd_pkg::VAL_W'(delta);
        if (val < 0)
        begin
            sample_next = '0;
        end
        else if (val > $signed(idsd_pkg::VAL_W'(idsd_pkg::SAMPLE_MAX)))
        begin
            sample_next = idsd_pkg::SAMPLE_MAX;
        end
        else
        begin
            sample_next = val[idsd_pkg::SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg    <= '0;
            output_enable_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                idsd_pkg::REG_PHASE_STEP:    phase_step_reg    <= cfg_data[idsd_pkg::PHASE_W-1:0];
                idsd_pkg::REG_OUTPUT_ENABLE: output_enable_reg <= cfg_data[0];
                default:                     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_accum_reg <= '0;
            rd_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (req_acc && (req.req_type == idsd_pkg::REQ_LOAD_PHASE))
            begin
                phase_accum_reg <= req.phase_value;
            end
            else if (tick_go)
            begin
                phase_accum_reg <= phase_accum_reg + phase_step_reg;
            end
            if (rd_free)
            begin
                rd_valid_reg <= tick_go;
            end
            if (out_adv)
            begin
                out_valid_reg <= rd_valid_reg;
            end
        end
    end

    // registered rom reads for current and next entry
    always_ff @(posedge clk)
    begin
        if (tick_go)
        begin
            cur_reg  <= SINE_ROM[idx];
            nxt_reg  <= SINE_ROM[nxt_idx];
            frac_reg <= frac;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_adv && rd_valid_reg)
        begin
            sample_reg <= sample_next;
        end
    end

endmodule
